FILE: rtl/prdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dirty rectangle finder package
// Shared widths, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package prdr_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int PIXEL_BITS = 16;
	localparam int STATUS_BITS = 2;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_CLEAN   = 2'd0,
		STATUS_DIRTY   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_REGION_LEFT   = 3'd2,
		REG_REGION_TOP    = 3'd3,
		REG_REGION_WIDTH  = 3'd4,
		REG_REGION_HEIGHT = 3'd5
	} cfg_reg_t;

endpackage

FILE: rtl/prdr_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel pair channel
// Carries one live pixel and one snapshot pixel per item.
// ----------------------------------------------------------------------------
interface prdr_pix_if
	import prdr_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] live_pixel;
	logic [PIXEL_BITS-1:0] saved_pixel;

	modport source (output valid, live_pixel, saved_pixel, input ready);
	modport sink (input valid, live_pixel, saved_pixel, output ready);
endinterface

FILE: rtl/prdr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries the status and the difference rectangle of one region pass.
// ----------------------------------------------------------------------------
interface prdr_res_if
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [COORD_BITS-1:0]  rect_x;
	logic [COORD_BITS-1:0]  rect_y;
	logic [COORD_BITS-1:0]  rect_width;
	logic [COORD_BITS-1:0]  rect_height;

	modport source (output valid, status, rect_x, rect_y, rect_width, rect_height,
		input ready);
	modport sink (input valid, status, rect_x, rect_y, rect_width, rect_height,
		output ready);
endinterface

FILE: rtl/prdr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface prdr_cfg_if
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [COORD_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/pixel_region_dirty_rect_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel region dirty rectangle finder
// Compares a live region with a snapshot in raster order and reports the
// bounding box of the differing pixels once per region pass.
// ----------------------------------------------------------------------------
//   Port  Role    Item
//   pix   sink    live_pixel and saved_pixel of one region position
//   res   source  status and rect_x, rect_y, rect_width, rect_height
//   cfg   sink    register index and write data, always ready
//
// One pixel pair is accepted every cycle unless the input stalls. Each pass
// result passes the input, record and output registers in that order.
// Reset clears the geometry registers, the position counters and the bounds.
// The input stalls only when one result is held in the output register,
// another waits behind it and the item in the input register gives a third.
module pixel_region_dirty_rect_finder
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	prdr_pix_if.sink   pix,
	prdr_res_if.source res,
	prdr_cfg_if.sink   cfg
);

	logic [COORD_BITS-1:0] region_left;
	logic [COORD_BITS-1:0] region_top;
	logic [COORD_BITS-1:0] region_width;
	logic [COORD_BITS-1:0] region_height;
	logic                  region_ok;
	logic                  rec_load_ok;
	logic                  rec_valid;
	status_t               rec_status;
	logic [COORD_BITS-1:0] rec_min_col;
	logic [COORD_BITS-1:0] rec_max_col;
	logic [COORD_BITS-1:0] rec_min_row;
	logic [COORD_BITS-1:0] rec_max_row;

	prdr_cfg_regs #(
		.COORD_BITS(COORD_BITS)
	) u_cfg_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.region_left  (region_left),
		.region_top   (region_top),
		.region_width (region_width),
		.region_height(region_height),
		.region_ok    (region_ok)
	);

	prdr_tracker #(
		.COORD_BITS(COORD_BITS)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pix),
		.region_ok    (region_ok),
		.region_width (region_width),
		.region_height(region_height),
		.rec_load_ok  (rec_load_ok),
		.rec_valid    (rec_valid),
		.rec_status   (rec_status),
		.rec_min_col  (rec_min_col),
		.rec_max_col  (rec_max_col),
		.rec_min_row  (rec_min_row),
		.rec_max_row  (rec_max_row)
	);

	prdr_result #(
		.COORD_BITS(COORD_BITS)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec_valid  (rec_valid),
		.rec_status (rec_status),
		.rec_min_col(rec_min_col),
		.rec_max_col(rec_max_col),
		.rec_min_row(rec_min_row),
		.rec_max_row(rec_max_row),
		.region_left(region_left),
		.region_top (region_top),
		.rec_load_ok(rec_load_ok),
		.res        (res)
	);

endmodule

FILE: rtl/prdr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the frame and region geometry and checks that the region fits.
// ----------------------------------------------------------------------------
module prdr_cfg_regs
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	prdr_cfg_if.sink              cfg,
	output logic [COORD_BITS-1:0] region_left,
	output logic [COORD_BITS-1:0] region_top,
	output logic [COORD_BITS-1:0] region_width,
	output logic [COORD_BITS-1:0] region_height,
	output logic                  region_ok
);

	logic [COORD_BITS-1:0] frame_width_q;
	logic [COORD_BITS-1:0] frame_height_q;
	logic [COORD_BITS-1:0] region_left_q;
	logic [COORD_BITS-1:0] region_top_q;
	logic [COORD_BITS-1:0] region_width_q;
	logic [COORD_BITS-1:0] region_height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= '0;
			frame_height_q  <= '0;
			region_left_q   <= '0;
			region_top_q    <= '0;
			region_width_q  <= '0;
			region_height_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg.data;
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg.data;
				REG_REGION_LEFT:   region_left_q   <= cfg.data;
				REG_REGION_TOP:    region_top_q    <= cfg.data;
				REG_REGION_WIDTH:  region_width_q  <= cfg.data;
				REG_REGION_HEIGHT: region_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		region_ok = (region_width_q != '0) && (region_height_q != '0) &&
			(region_left_q <= frame_width_q) &&
			(region_width_q <= frame_width_q - region_left_q) &&
			(region_top_q <= frame_height_q) &&
			(region_height_q <= frame_height_q - region_top_q);
	end

	assign region_left   = region_left_q;
	assign region_top    = region_top_q;
	assign region_width  = region_width_q;
	assign region_height = region_height_q;

endmodule

FILE: rtl/prdr_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mismatch tracker
// Registers each pixel pair, walks the region position and keeps the
// bounds of the differing pixels, then hands the end-of-pass record on.
// ----------------------------------------------------------------------------
module prdr_tracker
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	prdr_pix_if.sink              pix,
	input  logic                  region_ok,
	input  logic [COORD_BITS-1:0] region_width,
	input  logic [COORD_BITS-1:0] region_height,
	input  logic                  rec_load_ok,
	output logic                  rec_valid,
	output status_t               rec_status,
	output logic [COORD_BITS-1:0] rec_min_col,
	output logic [COORD_BITS-1:0] rec_max_col,
	output logic [COORD_BITS-1:0] rec_min_row,
	output logic [COORD_BITS-1:0] rec_max_row
);

	localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	logic                  item_valid_s1;
	logic [PIXEL_BITS-1:0] live_s1;
	logic [PIXEL_BITS-1:0] saved_s1;

	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] min_col_q;
	logic [COORD_BITS-1:0] max_col_q;
	logic [COORD_BITS-1:0] min_row_q;
	logic [COORD_BITS-1:0] max_row_q;
	logic                  any_q;

	logic                  rec_valid_s2;
	status_t               rec_status_s2;
	logic [COORD_BITS-1:0] min_col_s2;
	logic [COORD_BITS-1:0] max_col_s2;
	logic [COORD_BITS-1:0] min_row_s2;
	logic [COORD_BITS-1:0] max_row_s2;

	logic                  mismatch;
	logic                  row_end;
	logic                  last;
	logic                  produce;
	logic                  advance;
	logic                  fire;
	logic [COORD_BITS-1:0] nmin_col;
	logic [COORD_BITS-1:0] nmax_col;
	logic [COORD_BITS-1:0] nmin_row;
	logic [COORD_BITS-1:0] nmax_row;
	logic                  nany;

	always_comb begin
		mismatch = live_s1 != saved_s1;
		row_end  = col_q >= region_width - ONE;
		last     = row_end && !(row_q < region_height - ONE);
		produce  = !region_ok || last;
		advance  = !produce || !rec_valid_s2 || rec_load_ok;
		fire     = item_valid_s1 && advance;

		nmin_col = min_col_q;
		nmax_col = max_col_q;
		nmin_row = min_row_q;
		nmax_row = max_row_q;
		nany     = any_q;
		if (mismatch) begin
			nany = 1'b1;
			if (!any_q) begin
				nmin_col = col_q;
				nmax_col = col_q;
				nmin_row = row_q;
				nmax_row = row_q;
			end else begin
				if (col_q < min_col_q) nmin_col = col_q;
				if (col_q > max_col_q) nmax_col = col_q;
				if (row_q < min_row_q) nmin_row = row_q;
				if (row_q > max_row_q) nmax_row = row_q;
			end
		end
	end

	assign pix.ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			item_valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			live_s1  <= pix.live_pixel;
			saved_s1 <= pix.saved_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (fire && region_ok) begin
			if (last) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				any_q     <= 1'b0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + ONE;
				end else begin
					col_q <= col_q + ONE;
				end
				min_col_q <= nmin_col;
				max_col_q <= nmax_col;
				min_row_q <= nmin_row;
				max_row_q <= nmax_row;
				any_q     <= nany;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s2 <= 1'b0;
		end else if (fire && produce) begin
			rec_valid_s2 <= 1'b1;
		end else if (rec_load_ok) begin
			rec_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			if (!region_ok) begin
				rec_status_s2 <= STATUS_INVALID;
			end else if (nany) begin
				rec_status_s2 <= STATUS_DIRTY;
			end else begin
				rec_status_s2 <= STATUS_CLEAN;
			end
			min_col_s2 <= nmin_col;
			max_col_s2 <= nmax_col;
			min_row_s2 <= nmin_row;
			max_row_s2 <= nmax_row;
		end
	end

	assign rec_valid   = rec_valid_s2;
	assign rec_status  = rec_status_s2;
	assign rec_min_col = min_col_s2;
	assign rec_max_col = max_col_s2;
	assign rec_min_row = min_row_s2;
	assign rec_max_row = max_row_s2;

endmodule

FILE: rtl/prdr_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result formatter
// Turns the end-of-pass bounds into a frame rectangle and holds it in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module prdr_result
	import prdr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	input  status_t               rec_status,
	input  logic [COORD_BITS-1:0] rec_min_col,
	input  logic [COORD_BITS-1:0] rec_max_col,
	input  logic [COORD_BITS-1:0] rec_min_row,
	input  logic [COORD_BITS-1:0] rec_max_row,
	input  logic [COORD_BITS-1:0] region_left,
	input  logic [COORD_BITS-1:0] region_top,
	output logic                  rec_load_ok,
	prdr_res_if.source            res
);

	localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	logic                  out_valid_q;
	status_t               status_q;
	logic [COORD_BITS-1:0] rect_x_q;
	logic [COORD_BITS-1:0] rect_y_q;
	logic [COORD_BITS-1:0] rect_w_q;
	logic [COORD_BITS-1:0] rect_h_q;
	logic                  load;

	assign rec_load_ok = !out_valid_q || res.ready;
	assign load        = rec_valid && rec_load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_load_ok) begin
			out_valid_q <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= rec_status;
			if (rec_status == STATUS_DIRTY) begin
				rect_x_q <= region_left + rec_min_col;
				rect_y_q <= region_top + rec_min_row;
				rect_w_q <= rec_max_col - rec_min_col + ONE;
				rect_h_q <= rec_max_row - rec_min_row + ONE;
			end else begin
				rect_x_q <= '0;
				rect_y_q <= '0;
				rect_w_q <= '0;
				rect_h_q <= '0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = status_q;
	assign res.rect_x      = rect_x_q;
	assign res.rect_y      = rect_y_q;
	assign res.rect_width  = rect_w_q;
	assign res.rect_height = rect_h_q;

endmodule
